@@ sv/ksm_pkg.sv @@
package ksm_pkg;

	// Trie capacity in nodes, the root included
	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);

	localparam int KEY_W = 9;
	localparam int ACT_W = 8;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [ACT_W-1:0]  act_t;

	typedef enum logic [2:0] {
		ST_PENDING    = 3'd0,
		ST_MATCHED    = 3'd1,
		ST_NOMATCH    = 3'd2,
		ST_PROGRAMMED = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	typedef enum logic {
		MODE_MATCH   = 1'b0,
		MODE_PROGRAM = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_RESOLVE,
		FSM_ACT,
		FSM_DONE
	} fsm_t;

	// One edge table entry; the child of edge i is always node i+1
	typedef struct packed {
		node_t parent;
		key_t  key;
	} edge_t;

endpackage

@@ sv/ksm_ifs.sv @@
interface ksm_req_if import ksm_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	key_t key_code;
	logic last_key;
	act_t action_id;

	modport source (output valid, mode, key_code, last_key, action_id, input ready);
	modport sink (input valid, mode, key_code, last_key, action_id, output ready);
endinterface

interface ksm_rsp_if import ksm_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	act_t    matched_action;
	key_t    matched_key;

	modport source (output valid, status, matched_action, matched_key, input ready);
	modport sink (input valid, status, matched_action, matched_key, output ready);
endinterface

@@ sv/key_sequence_trie_matcher_core.sv @@
// Key sequence trie matcher. Each request word carries one key: in program
// mode it extends the sequence being programmed (following an existing edge
// or making a new node; with the table full a new key only reports ST_FULL
// and goes back to the root), and the word marked last_key attaches
// action_id to the reached node and returns the programming cursor to the
// root; in match mode the match cursor follows the key's edge (a missing
// edge returns it to the root) and a node with a nonzero handler reports a
// match and returns to the root. Every request word yields exactly one
// response word. The trie lives in two synchronous RAMs: an edge table
// (parent, key), entry i leading to node i+1, and a per-node handler table.
// One word is in flight at a time. The edge RAM is scanned linearly at one
// entry per cycle over the edges in use (nodes in use minus one), and a
// match adds one handler RAM read; a response held in the output register
// stalls the block. A finished response may wait there while the next word
// is taken. After reset the trie holds only the root and is ready at once.
module key_sequence_trie_matcher_core import ksm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ksm_req_if.sink   req,
	ksm_rsp_if.source rsp
);

	// Memories
	edge_t edge_mem [MAX_NODES];
	act_t  act_mem  [MAX_NODES];

	fsm_t state_q, state_d;

	// Control state
	cnt_t  nodes_q;
	node_t prog_cur_q;
	node_t match_cur_q;
	cnt_t  idx_q;
	logic  rd_vld_s1;
	node_t rd_idx_s1;
	logic  found_q;
	logic  rsp_vld_q;

	// Latched word and scan result
	logic  mode_q;
	key_t  key_q;
	logic  last_q;
	act_t  act_q;
	node_t child_q;

	// Pending response
	status_t res_status_q;
	act_t    res_act_q;
	key_t    res_key_q;
	status_t rsp_status_q;
	act_t    rsp_act_q;
	key_t    rsp_key_q;

	// Memory ports
	edge_t edge_rd_s1;
	act_t  act_rd_s1;
	logic  edge_we;
	node_t edge_waddr;
	logic  act_we;
	node_t act_waddr;
	act_t  act_wdata;

	cnt_t  edges;
	node_t cursor;
	node_t new_node;
	logic  hit;
	logic  issue;
	logic  full;
	logic  out_free;
	logic  accept;

	assign edges    = nodes_q - cnt_t'(1);
	assign cursor   = (mode_q == MODE_PROGRAM) ? prog_cur_q : match_cur_q;
	assign new_node = nodes_q[NODE_W-1:0];
	assign full     = (nodes_q == cnt_t'(MAX_NODES));
	assign hit      = rd_vld_s1 && (edge_rd_s1.parent == cursor) && (edge_rd_s1.key == key_q);
	assign issue    = (state_q == FSM_SCAN) && !hit && (idx_q < edges);
	assign out_free = !rsp_vld_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	assign req.ready          = (state_q == FSM_IDLE);
	assign rsp.valid          = rsp_vld_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.matched_action = rsp_act_q;
	assign rsp.matched_key    = rsp_key_q;

	// Table writes happen only while resolving a program word
	assign edge_we    = (state_q == FSM_RESOLVE) && (mode_q == MODE_PROGRAM) && !found_q && !full;
	assign edge_waddr = edges[NODE_W-1:0];
	assign act_we     = (state_q == FSM_RESOLVE) && (mode_q == MODE_PROGRAM)
		&& (found_q ? last_q : !full);
	assign act_waddr  = found_q ? child_q : new_node;
	assign act_wdata  = last_q ? act_q : '0;

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_waddr] <= '{parent: prog_cur_q, key: key_q};
		end
		edge_rd_s1 <= edge_mem[idx_q[NODE_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (act_we) begin
			act_mem[act_waddr] <= act_wdata;
		end
		act_rd_s1 <= act_mem[child_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req.valid) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				// Stop on a hit, or once every edge has been read and checked
				if (hit || (!issue && !rd_vld_s1)) begin
					state_d = FSM_RESOLVE;
				end
			end
			FSM_RESOLVE: begin
				state_d = ((mode_q == MODE_MATCH) && found_q) ? FSM_ACT : FSM_DONE;
			end
			FSM_ACT: begin
				state_d = FSM_DONE;
			end
			FSM_DONE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q     <= cnt_t'(1);
			prog_cur_q  <= '0;
			match_cur_q <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			rsp_vld_q   <= 1'b0;
		end else begin
			if (state_q == FSM_DONE && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			case (state_q)
				FSM_IDLE: begin
					idx_q     <= '0;
					rd_vld_s1 <= 1'b0;
					found_q   <= 1'b0;
				end
				FSM_SCAN: begin
					// Advance the read address; the data returns in the next cycle
					rd_vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + cnt_t'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				FSM_RESOLVE: begin
					if (mode_q == MODE_PROGRAM) begin
						if (found_q) begin
							prog_cur_q <= last_q ? '0 : child_q;
						end else if (full) begin
							prog_cur_q <= '0;
						end else begin
							nodes_q    <= nodes_q + cnt_t'(1);
							prog_cur_q <= last_q ? '0 : new_node;
						end
					end else if (!found_q) begin
						match_cur_q <= '0;
					end
				end
				FSM_ACT: begin
					match_cur_q <= (act_rd_s1 != '0) ? '0 : child_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			key_q  <= req.key_code;
			last_q <= req.last_key;
			act_q  <= req.action_id;
		end

		rd_idx_s1 <= idx_q[NODE_W-1:0];
		if (state_q == FSM_SCAN && hit) begin
			child_q <= rd_idx_s1 + node_t'(1);
		end

		if (state_q == FSM_RESOLVE) begin
			res_act_q <= '0;
			res_key_q <= '0;
			if (mode_q == MODE_PROGRAM) begin
				if (!found_q && full) begin
					res_status_q <= ST_FULL;
				end else begin
					res_status_q <= last_q ? ST_PROGRAMMED : ST_PENDING;
				end
			end else begin
				res_status_q <= ST_NOMATCH;
			end
		end

		if (state_q == FSM_ACT) begin
			if (act_rd_s1 != '0) begin
				res_status_q <= ST_MATCHED;
				res_act_q    <= act_rd_s1;
				res_key_q    <= key_q;
			end else begin
				res_status_q <= ST_PENDING;
			end
		end

		// Hold the response until taken, then load the next one
		if (state_q == FSM_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_act_q    <= res_act_q;
			rsp_key_q    <= res_key_q;
		end
	end

endmodule

@@ sv/ksm_checker.sv @@
module ksm_checker import ksm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    req_valid,
	input logic    req_ready,
	input logic    rsp_valid,
	input logic    rsp_ready,
	input status_t rsp_status,
	input act_t    rsp_matched_action,
	input key_t    rsp_matched_key
);

	// A stalled response word holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_matched_action) && $stable(rsp_matched_key))
		else $error("response word changed while stalled");

	// One word in flight: no request taken right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous word in flight");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_MATCHED |->
			rsp_matched_action == '0 && rsp_matched_key == '0)
		else $error("match fields set on a non-match response");

	a_match_handler: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_MATCHED |-> rsp_matched_action != '0)
		else $error("match reported with no handler");

endmodule

bind key_sequence_trie_matcher_core ksm_checker u_ksm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_matched_action (rsp.matched_action),
	.rsp_matched_key    (rsp.matched_key)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import ksm_pkg::*;

	// One response word as the checker sees it
	typedef struct packed {
		status_t status;
		act_t    action;
		key_t    key;
	} outcome_t;

	logic clk;
	logic arst_n;

	ksm_req_if req_if ();
	ksm_rsp_if rsp_if ();

	key_sequence_trie_matcher_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow trie: edge i leads from trie_parent[i] along trie_key[i] to node i+1
	node_t trie_parent [MAX_NODES-1];
	key_t  trie_key [MAX_NODES-1];
	act_t  node_handler [MAX_NODES];
	int    node_count;
	node_t prog_at;
	node_t match_at;

	// Responses still owed by the block, oldest first
	outcome_t awaited_rsp [$];
	outcome_t rsp_want;
	outcome_t rsp_got;

	int words_sent  = 0;
	int fault_count = 0;
	int stall_left  = 0;
	bit calm        = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Trie prediction
	// ------------------------------------------------------------------

	// Scan only the edges in use; return the child node or -1
	function automatic int lookup_child(node_t from, key_t k);
		for (int i = 0; i < node_count - 1; i++) begin
			if (trie_parent[i] == from && trie_key[i] == k)
				return i + 1;
		end
		return -1;
	endfunction

	// Advance the shadow trie by one request word and return the response it owes
	function automatic outcome_t predict_key(mode_t m, key_t k, logic last, act_t a);
		outcome_t o;
		int       child;
		o.status = ST_PENDING;
		o.action = '0;
		o.key    = '0;
		if (m == MODE_PROGRAM) begin
			child = lookup_child(prog_at, k);
			if (child >= 0) begin
				prog_at = node_t'(child);
			end else if (node_count >= MAX_NODES) begin
				// No room for a new node: abandon the sequence, touch nothing
				prog_at  = '0;
				o.status = ST_FULL;
			end else begin
				trie_parent[node_count-1] = prog_at;
				trie_key[node_count-1]    = k;
				node_handler[node_count]  = '0;
				prog_at                   = node_t'(node_count);
				node_count++;
			end
			if (o.status != ST_FULL && last) begin
				node_handler[prog_at] = a;
				prog_at               = '0;
				o.status              = ST_PROGRAMMED;
			end
		end else begin
			child = lookup_child(match_at, k);
			if (child < 0) begin
				// Drop the key; it is not retried from the root
				match_at = '0;
				o.status = ST_NOMATCH;
			end else if (node_handler[child] != '0) begin
				o.action = node_handler[child];
				o.key    = k;
				match_at = '0;
				o.status = ST_MATCHED;
			end else begin
				match_at = node_t'(child);
			end
		end
		return o;
	endfunction

	// Pick a random edge leaving a node; -1 when the node is a leaf
	function automatic int pick_edge(node_t from);
		int hits;
		int pick;
		hits = 0;
		for (int i = 0; i < node_count - 1; i++)
			if (trie_parent[i] == from)
				hits++;
		if (hits == 0)
			return -1;
		pick = $urandom_range(0, hits - 1);
		for (int i = 0; i < node_count - 1; i++) begin
			if (trie_parent[i] == from) begin
				if (pick == 0)
					return i;
				pick--;
			end
		end
		return -1;
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// Favor a small alphabet so sequences share prefixes, keep full range and extremes
	function automatic key_t rand_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return key_t'($urandom_range(0, 7));
		if (r == 4)
			return $urandom_range(0, 1) ? key_t'(511) : key_t'(0);
		return key_t'($urandom_range(0, 511));
	endfunction

	function automatic act_t rand_action();
		if ($urandom_range(0, 99) < 15)
			return '0;
		return act_t'($urandom_range(1, 255));
	endfunction

	// Back to back while calm; else mostly back to back, sometimes a short gap, rarely a long pause
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Response side: random back-pressure and checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (calm) begin
			rsp_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					rsp_if.ready <= 1'b0;
					stall_left   <= $urandom_range(0, 2);
				end
				3: begin
					rsp_if.ready <= 1'b0;
					stall_left   <= $urandom_range(8, 40);
				end
				default: begin
					rsp_if.ready <= 1'b1;
				end
			endcase
		end
	end

	function automatic void log_fault(string what, outcome_t want, outcome_t got);
		fault_count++;
		if (fault_count <= 10) begin
			$write("%0t %s: expected status %0d action %0d key %0d, ",
				$time, what, want.status, want.action, want.key);
			$display("got status %0d action %0d key %0d",
				got.status, got.action, got.key);
		end
	endfunction

	// Compare every accepted response word against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			rsp_got = {rsp_if.status, rsp_if.matched_action, rsp_if.matched_key};
			if (awaited_rsp.size() == 0) begin
				log_fault("response with nothing awaited", '0, rsp_got);
			end else begin
				rsp_want = awaited_rsp.pop_front();
				if (rsp_got.status != rsp_want.status || rsp_got.action != rsp_want.action
						|| rsp_got.key != rsp_want.key)
					log_fault("response mismatch", rsp_want, rsp_got);
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Present one word, hold it until accepted, then book its response.
	// Valid stays high after acceptance; the next call either replaces the
	// word in the same step or drops valid for a gap.
	task automatic send_word(mode_t m, key_t k, logic last, act_t a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.mode      <= m;
		req_if.key_code  <= k;
		req_if.last_key  <= last;
		req_if.action_id <= a;
		do @(posedge clk); while (!req_if.ready);
		awaited_rsp.insert(awaited_rsp.size(), predict_key(m, k, last, a));
		words_sent++;
	endtask

	// Drop valid and hold until every owed response has come back
	task automatic drain();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (awaited_rsp.size() != 0);
	endtask

	task automatic send_noise();
		send_word(mode_t'($urandom_range(0, 1)), key_t'($urandom_range(0, 511)),
			1'($urandom_range(0, 1)), act_t'($urandom_range(0, 255)));
	endtask

	// Program one sequence: follow existing edges about half the time
	task automatic program_sequence();
		int   len;
		int   e;
		key_t k;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
		for (int i = 0; i < len; i++) begin
			e = pick_edge(prog_at);
			k = (e >= 0 && $urandom_range(0, 1)) ? trie_key[e] : rand_key();
			send_word(MODE_PROGRAM, k, i == len - 1, rand_action());
		end
	endtask

	// Walk a stored path in match mode until a handler fires or a leaf is
	// reached; now and then break the path with a stray key
	task automatic match_sequence();
		int    e;
		int    start;
		bit    done;
		node_t at;
		key_t  k;
		start = words_sent;
		// Return the match cursor to the root with a key it has no edge for
		if (match_at != '0) begin
			do k = key_t'($urandom_range(0, 511)); while (lookup_child(match_at, k) >= 0);
			send_word(MODE_MATCH, k, 1'($urandom_range(0, 1)), act_t'($urandom_range(0, 255)));
		end
		at   = '0;
		done = 1'b0;
		while (!done) begin
			e = pick_edge(at);
			if (e < 0) begin
				done = 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				send_word(MODE_MATCH, rand_key(), 1'($urandom_range(0, 1)), rand_action());
				done = 1'b1;
			end else begin
				send_word(MODE_MATCH, trie_key[e], 1'($urandom_range(0, 1)),
					act_t'($urandom_range(0, 255)));
				at   = match_at;
				done = (match_at == '0);
			end
		end
		if (words_sent == start)
			send_noise();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked words: key extremes, handler 0 and 255, missing edges at
	// the root and mid-path, prefix without handler, shadowed longer paths
	task automatic test_basics();
		send_word(MODE_MATCH,   9'd5,   1'b0, 8'd0);    // empty trie, miss at the root
		send_word(MODE_PROGRAM, 9'd0,   1'b0, 8'd77);   // new node, prefix pending
		send_word(MODE_PROGRAM, 9'd511, 1'b1, 8'd255);  // finish [0,511] with 255
		send_word(MODE_PROGRAM, 9'd0,   1'b1, 8'd0);    // follow edge, handler stays clear
		send_word(MODE_MATCH,   9'd0,   1'b1, 8'd255);  // step without a handler
		send_word(MODE_MATCH,   9'd511, 1'b0, 8'd0);    // match 255
		send_word(MODE_MATCH,   9'd0,   1'b0, 8'd0);
		send_word(MODE_MATCH,   9'd3,   1'b0, 8'd0);    // miss mid-path
		send_word(MODE_MATCH,   9'd511, 1'b0, 8'd0);    // dropped, not retried at the root
		send_word(MODE_PROGRAM, 9'd0,   1'b1, 8'd1);    // handler on the prefix
		send_word(MODE_MATCH,   9'd0,   1'b0, 8'd0);    // prefix fires first
		send_word(MODE_MATCH,   9'd511, 1'b0, 8'd0);
		send_word(MODE_PROGRAM, 9'd0,   1'b1, 8'd0);    // clear the prefix again
		send_word(MODE_MATCH,   9'd0,   1'b0, 8'd0);
		send_word(MODE_MATCH,   9'd511, 1'b0, 8'd0);
		send_word(MODE_PROGRAM, 9'd256, 1'b1, 8'd128);
		send_word(MODE_MATCH,   9'd256, 1'b1, 8'd255);
		send_word(MODE_PROGRAM, 9'd256, 1'b0, 8'd0);    // extend below a handler node
		send_word(MODE_PROGRAM, 9'd255, 1'b0, 8'd0);
		send_word(MODE_PROGRAM, 9'd1,   1'b1, 8'd170);
		send_word(MODE_MATCH,   9'd256, 1'b0, 8'd85);   // fires before the deeper path
		send_word(MODE_MATCH,   9'd255, 1'b0, 8'd0);
	endtask

	// Programming and matching mixed while the trie still grows
	task automatic test_mixed_traffic(int target);
		int r;
		while (words_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				program_sequence();
			else if (r < 85)
				match_sequence();
			else
				send_noise();
		end
	endtask

	// Fill the node table, then hit the full case where the cursor stands and again mid-sequence
	task automatic test_table_full();
		key_t k;
		int   e;
		while (node_count < MAX_NODES) begin
			do k = key_t'($urandom_range(0, 511)); while (lookup_child(prog_at, k) >= 0);
			send_word(MODE_PROGRAM, k, 1'($urandom_range(0, 1)), rand_action());
		end
		do k = key_t'($urandom_range(0, 511)); while (lookup_child(prog_at, k) >= 0);
		send_word(MODE_PROGRAM, k, 1'b1, rand_action());
		e = pick_edge('0);
		if (e >= 0) begin
			send_word(MODE_PROGRAM, trie_key[e], 1'b0, rand_action());
			do k = key_t'($urandom_range(0, 511)); while (lookup_child(prog_at, k) >= 0);
			send_word(MODE_PROGRAM, k, 1'b0, rand_action());
			// Cursor is back at the root: reprogram an existing single-key path
			send_word(MODE_PROGRAM, trie_key[e], 1'b1, rand_action());
		end
	endtask

	// Mostly matching on the full trie; the first stretch runs without idling
	task automatic test_full_trie_traffic(int target);
		int r;
		calm = 1'b1;
		while (words_sent < target) begin
			if (calm && words_sent >= 1000)
				calm = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 10)
				program_sequence();
			else if (r < 90)
				match_sequence();
			else
				send_noise();
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.mode      <= MODE_MATCH;
		req_if.key_code  <= '0;
		req_if.last_key  <= 1'b0;
		req_if.action_id <= '0;

		// Shadow trie starts as the bare root
		for (int i = 0; i < MAX_NODES; i++)
			node_handler[i] = '0;
		node_count = 1;
		prog_at    = '0;
		match_at   = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basics();
		test_mixed_traffic(700);
		// Hold the sender until the block has answered everything
		drain();
		test_table_full();
		test_full_trie_traffic(1900);
		drain();
		// Allow for one worst-case scan in case a stray word is still coming
		repeat (MAX_NODES + 8) @(posedge clk);

		if (fault_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
